// ===== rtl/psseg_pkg.sv =====
// Shared types and constants for the power state segmenter.
`timescale 1ns / 1ps

package psseg_pkg;

   localparam int SAMPLE_W     = 20;
   localparam int WATT_W       = 16;
   localparam int OUT_TIME_W   = 48;
   localparam int PERIOD_W     = 16;
   localparam int STATE_IDX_W  = 2;
   localparam int RANGE_REGS   = 4;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int RIU_W        = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_0       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_3       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGES_IN_USE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_PERIOD = 3'd5;

   localparam logic [WATT_W-1:0] WATT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [SAMPLE_W-1:0] power_sample;
      logic                end_of_trace;
   } req_type;

   typedef struct packed {
      logic [STATE_IDX_W-1:0] state_index;
      logic [OUT_TIME_W-1:0]  start_time;
      logic [OUT_TIME_W-1:0]  end_time;
      logic                   closed_by_end;
      logic                   last_of_run;
   } rsp_type;

   // All results caused by one sample; res0 always holds a result.
   typedef struct packed {
      logic    has_second;
      rsp_type res0;
      rsp_type res1;
   } event_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== rtl/psseg_front.sv =====
// Front end: rounds and classifies samples, tracks the open segment, builds result events.
`timescale 1ns / 1ps

module psseg_front #(
   parameter int NUM_RANGES = 4,
   parameter int TIME_WIDTH = 48
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  psseg_pkg::req_type                  req_data,
   input  logic                                csr_write,
   input  logic [psseg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [psseg_pkg::CSR_DATA_W-1:0]    csr_data,
   input  psseg_pkg::queue_status_type         q_status,
   output logic                                push_valid,
   output psseg_pkg::event_type                push_data
);
   import psseg_pkg::*;

   localparam int LIVE_RANGES = (NUM_RANGES < RANGE_REGS) ? NUM_RANGES : RANGE_REGS;

   logic [CSR_DATA_W-1:0]  range_ff [LIVE_RANGES];
   logic [RIU_W-1:0]       riu_ff;
   logic [PERIOD_W-1:0]    period_ff;

   logic                   inside_ff, inside_in;
   logic [STATE_IDX_W-1:0] open_idx_ff, open_idx_in;
   logic [TIME_WIDTH-1:0]  open_start_ff, open_start_in;
   logic [TIME_WIDTH-1:0]  time_ff, time_in;

   logic                   accept;
   logic [SAMPLE_W:0]      rounded;
   logic [WATT_W:0]        watts_wide;
   logic [WATT_W-1:0]      watts;
   logic                   hit;
   logic [STATE_IDX_W-1:0] hit_idx;
   logic                   emit_left;
   logic                   emit_flush;
   logic [TIME_WIDTH-1:0]  time_next;
   rsp_type                left_res;
   rsp_type                flush_res;

   function automatic logic [OUT_TIME_W-1:0] to_out_time(input logic [TIME_WIDTH-1:0] t);
      logic [TIME_WIDTH+OUT_TIME_W-1:0] wide;
      wide = {{OUT_TIME_W{1'b0}}, t};
      return wide[OUT_TIME_W-1:0];
   endfunction

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   // Round half up to whole watts, then saturate.
   assign rounded    = {1'b0, req_data.power_sample} + (SAMPLE_W+1)'(8);
   assign watts_wide = rounded[SAMPLE_W:4];
   assign watts      = watts_wide[WATT_W] ? WATT_MAX : watts_wide[WATT_W-1:0];

   // The lowest-numbered active range that holds the value wins.
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int k = LIVE_RANGES - 1; k >= 0; k--) begin
         if ((RIU_W'(k) < riu_ff) &&
             (watts >= range_ff[k][WATT_W-1:0]) &&
             (watts <= range_ff[k][CSR_DATA_W-1:WATT_W])) begin
            hit     = 1'b1;
            hit_idx = STATE_IDX_W'(k);
         end
      end
   end

   assign time_next = time_ff + {{(TIME_WIDTH-PERIOD_W){1'b0}}, period_ff};

   always_comb begin
      emit_left     = inside_ff && (!hit || (hit_idx != open_idx_ff));
      inside_in     = inside_ff;
      open_idx_in   = open_idx_ff;
      open_start_in = open_start_ff;
      if (inside_ff) begin
         if (emit_left) begin
            if (hit) begin
               open_idx_in   = hit_idx;
               open_start_in = time_ff;
            end else begin
               inside_in = 1'b0;
            end
         end
      end else if (hit) begin
         inside_in     = 1'b1;
         open_idx_in   = hit_idx;
         open_start_in = time_ff;
      end

      emit_flush = req_data.end_of_trace && inside_in;

      left_res.state_index   = open_idx_ff;
      left_res.start_time    = to_out_time(open_start_ff);
      left_res.end_time      = to_out_time(time_ff);
      left_res.closed_by_end = 1'b0;
      left_res.last_of_run   = !emit_flush;

      flush_res.state_index   = open_idx_in;
      flush_res.start_time    = to_out_time(open_start_in);
      flush_res.end_time      = to_out_time(time_next);
      flush_res.closed_by_end = 1'b1;
      flush_res.last_of_run   = 1'b1;

      // The end of a trace puts the segment tracking back to its reset values.
      if (req_data.end_of_trace) begin
         inside_in     = 1'b0;
         open_idx_in   = '0;
         open_start_in = '0;
         time_in       = '0;
      end else begin
         time_in = time_next;
      end
   end

   assign push_valid           = accept && (emit_left || emit_flush);
   assign push_data.has_second = emit_left && emit_flush;
   assign push_data.res0       = emit_left ? left_res : flush_res;
   assign push_data.res1       = flush_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff     <= 1'b0;
         open_idx_ff   <= '0;
         open_start_ff <= '0;
         time_ff       <= '0;
      end else if (accept) begin
         inside_ff     <= inside_in;
         open_idx_ff   <= open_idx_in;
         open_start_ff <= open_start_in;
         time_ff       <= time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LIVE_RANGES; k++) begin
            range_ff[k] <= '0;
         end
         riu_ff    <= RIU_W'(1);
         period_ff <= PERIOD_W'(1);
      end else if (csr_write) begin
         for (int k = 0; k < LIVE_RANGES; k++) begin
            if ((csr_index >= CSR_RANGE_0) && (csr_index <= CSR_RANGE_3) &&
                (csr_index == CSR_INDEX_W'(k))) begin
               range_ff[k] <= csr_data;
            end
         end
         if (csr_index == CSR_RANGES_IN_USE) begin
            riu_ff <= csr_data[RIU_W-1:0];
         end
         if (csr_index == CSR_SAMPLE_PERIOD) begin
            period_ff <= csr_data[PERIOD_W-1:0];
         end
      end
   end

endmodule

// ===== rtl/psseg_queue.sv =====
// Short event queue between the front end and the output stage.
`timescale 1ns / 1ps

module psseg_queue #(
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   input  psseg_pkg::event_type         push_data,
   input  logic                         pop,
   output psseg_pkg::queue_status_type  q_status,
   output psseg_pkg::event_type         head_data
);
   import psseg_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   event_type        entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_data      = entry_ff[rd_ptr_ff];

   assign do_push = push_valid && !q_status.full;
   assign do_pop  = pop && !q_status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/psseg_back.sv =====
// Output stage: splits queued events into single results behind an output register.
`timescale 1ns / 1ps

module psseg_back (
   input  logic                         clock,
   input  logic                         reset,
   input  psseg_pkg::queue_status_type  q_status,
   input  psseg_pkg::event_type         head_data,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output psseg_pkg::rsp_type           rsp_data
);
   import psseg_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    second_valid_ff, second_valid_in;
   rsp_type second_ff, second_in;
   logic    load_ok;

   assign load_ok = !rsp_valid_ff || !rsp_stall;
   // A held second result goes out before the next event is taken.
   assign pop     = load_ok && !second_valid_ff && !q_status.empty;

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      second_valid_in = second_valid_ff;
      second_in       = second_ff;
      if (load_ok) begin
         priority if (second_valid_ff) begin
            rsp_valid_in    = 1'b1;
            rsp_data_in     = second_ff;
            second_valid_in = 1'b0;
         end else if (!q_status.empty) begin
            rsp_valid_in    = 1'b1;
            rsp_data_in     = head_data.res0;
            second_valid_in = head_data.has_second;
            second_in       = head_data.res1;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         second_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff    <= rsp_valid_in;
         second_valid_ff <= second_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      second_ff   <= second_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/power_state_segmenter.sv =====
// Top level of the power state segmenter.
`timescale 1ns / 1ps
//
// Power samples (watts with 4 fraction bits) enter on the req_ channel, one transfer per
// sample, with end_of_trace marking the last sample of a trace. Each segment that leaves
// a recognized power state comes out on the rsp_ channel as one transfer; last_of_run
// flags the final result a sample caused. Ranges, the number of ranges in use and the
// sample period are written on the csr_ port, by the user only while the block is idle;
// the block does not enforce this. The front end accepts one sample per cycle while the
// queue is not full: rounding, the parallel range compare and the segment update are
// combinational. When the output is free, a sample's first result passes through the
// event queue and then the output register to rsp_valid. The output register sends one
// result per cycle while rsp_stall is low, so a sample that both changes state and ends
// the trace gives two results in turn; the event queue (QUEUE_DEPTH entries) absorbs
// that and any rsp_stall. When rsp_stall holds, the result in the output register stays,
// the queue fills and req_stall rises once it is full.
// Reset clears the queue, the output register, the segment tracking and time, and sets
// the registers to ranges of zero, one range in use and a sample period of one.
//
module power_state_segmenter #(
   parameter int NUM_RANGES  = 4,
   parameter int TIME_WIDTH  = 48,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  psseg_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output psseg_pkg::rsp_type                  rsp_data,
   input  logic                                csr_write,
   input  logic [psseg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [psseg_pkg::CSR_DATA_W-1:0]    csr_data
);
   import psseg_pkg::*;

   queue_status_type q_status;
   logic             push_valid;
   event_type        push_data;
   logic             pop;
   event_type        head_data;

   psseg_front #(
      .NUM_RANGES (NUM_RANGES),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   psseg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .q_status   (q_status),
      .head_data  (head_data)
   );

   psseg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_data (head_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/sv/psseg_tb_pkg.sv =====
// Segment predictor and result checker for the power state segmenter testbench.
`timescale 1ns / 1ps

package psseg_tb_pkg;

   import psseg_pkg::*;

   // Register indexes that the block does not decode; writes to them must be ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_HI = 3'd7;

   class segment_predictor;

      logic [CSR_DATA_W-1:0]  range_word [RANGE_REGS];
      logic [RIU_W-1:0]       ranges_active;
      logic [PERIOD_W-1:0]    period;
      bit                     in_state;
      logic [STATE_IDX_W-1:0] seg_index;
      logic [OUT_TIME_W-1:0]  seg_start;
      logic [OUT_TIME_W-1:0]  trace_time;
      rsp_type                expected_segments[$];
      int                     failures;

      function new();
         foreach (range_word[k]) range_word[k] = '0;
         ranges_active = 1;
         period = 1;
         failures = 0;
         restart_trace();
      endfunction

      function void restart_trace();
         in_state = 0;
         seg_index = '0;
         seg_start = '0;
         trace_time = '0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx <= CSR_RANGE_3) begin
            range_word[idx - CSR_RANGE_0] = data;
         end else if (idx == CSR_RANGES_IN_USE) begin
            ranges_active = data[RIU_W-1:0];
         end else if (idx == CSR_SAMPLE_PERIOD) begin
            period = data[PERIOD_W-1:0];
         end
      endfunction

      function rsp_type make_segment(logic [STATE_IDX_W-1:0] idx, logic [OUT_TIME_W-1:0] t0,
                                     logic [OUT_TIME_W-1:0] t1, logic by_end);
         rsp_type r;
         r.state_index = idx;
         r.start_time = t0;
         r.end_time = t1;
         r.closed_by_end = by_end;
         r.last_of_run = 1'b0;
         return r;
      endfunction

      // Works out the segments that one accepted sample transfer closes.
      function void take_sample(req_type s);
         logic [SAMPLE_W:0]      rounded;
         logic [WATT_W-1:0]      watts;
         logic [STATE_IDX_W-1:0] found;
         logic [OUT_TIME_W-1:0]  next_time;
         bit                     hit;
         int                     active;
         rsp_type                made[$];
         rounded = {1'b0, s.power_sample} + 8;
         watts = rounded[SAMPLE_W] ? WATT_MAX : rounded[SAMPLE_W-1:4];
         active = (ranges_active > RANGE_REGS) ? RANGE_REGS : ranges_active;
         hit = 0;
         found = '0;
         // Scanning downward leaves the lowest matching index in found.
         for (int k = active - 1; k >= 0; k--) begin
            if (watts >= range_word[k][15:0] && watts <= range_word[k][31:16]) begin
               hit = 1;
               found = STATE_IDX_W'(k);
            end
         end
         next_time = trace_time + OUT_TIME_W'(period);
         if (in_state) begin
            if (!hit || found != seg_index) begin
               made.insert(made.size(), make_segment(seg_index, seg_start, trace_time, 1'b0));
               if (hit) begin
                  seg_index = found;
                  seg_start = trace_time;
               end else begin
                  in_state = 0;
               end
            end
         end else if (hit) begin
            in_state = 1;
            seg_index = found;
            seg_start = trace_time;
         end
         if (s.end_of_trace) begin
            if (in_state)
               made.insert(made.size(), make_segment(seg_index, seg_start, next_time, 1'b1));
            restart_trace();
         end else begin
            trace_time = next_time;
         end
         if (made.size() > 0) made[made.size() - 1].last_of_run = 1'b1;
         foreach (made[i]) expected_segments.insert(expected_segments.size(), made[i]);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_segment(rsp_type got);
         rsp_type want;
         if (expected_segments.size() == 0) begin
            $error("segment transfer with none expected: state_index %0d start %0d end %0d",
                   got.state_index, got.start_time, got.end_time);
            failures++;
            return;
         end
         want = expected_segments.pop_front();
         compare_field("state_index", want.state_index, got.state_index);
         compare_field("start_time", want.start_time, got.start_time);
         compare_field("end_time", want.end_time, got.end_time);
         compare_field("closed_by_end", want.closed_by_end, got.closed_by_end);
         compare_field("last_of_run", want.last_of_run, got.last_of_run);
      endfunction

      function int outstanding();
         return expected_segments.size();
      endfunction

   endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// Top level of the power state segmenter testbench: clock, stimulus, idling and checking.
`timescale 1ns / 1ps

module tb_top;

   import psseg_pkg::*;
   import psseg_tb_pkg::*;

   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_CYCLES  = 80;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   segment_predictor segments;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int phase_idle_pct = 0;
   int phase_stall_pct = 0;
   int hold_requests = 0;
   int range_lo [RANGE_REGS];
   int range_hi [RANGE_REGS];

   power_state_segmenter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("power_state_segmenter test failed");
      $finish;
   end

   // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
   initial begin
      int hold_taken;
      int hold_left;
      hold_taken = 0;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_taken) begin
            hold_taken = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write) segments.write_register(csr_index, csr_data);
         if (req_valid && !req_stall) segments.take_sample(req_data);
         if (rsp_valid && !rsp_stall) segments.check_segment(rsp_data);
      end
   end

   // Produces a sample that rounds to the given whole-watt value.
   function automatic logic [SAMPLE_W-1:0] sample_for_watts(int w);
      if (w <= 0) return SAMPLE_W'($urandom_range(7));
      if (w >= int'(WATT_MAX))
         return SAMPLE_W'($urandom_range((1 << SAMPLE_W) - 1, int'(WATT_MAX) * 16 - 8));
      return SAMPLE_W'(w * 16 - 8 + $urandom_range(15));
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_sample(logic [SAMPLE_W-1:0] p, logic eot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{power_sample: p, end_of_trace: eot};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // Waits until every expected segment has arrived and the pipeline has emptied.
   task automatic settle();
      req_valid <= 1'b0;
      while (segments.outstanding() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic program_ranges();
      int lo;
      int hi;
      int pick;
      for (int k = 0; k < RANGE_REGS; k++) begin
         pick = $urandom_range(9);
         lo = $urandom_range(int'(WATT_MAX));
         hi = lo + $urandom_range(2000);
         if (hi > int'(WATT_MAX)) hi = int'(WATT_MAX);
         if (pick == 0) begin
            lo = 0;
            hi = int'(WATT_MAX);
         end else if (pick == 1) begin
            hi = lo;
         end else if (pick == 2 && lo > 0) begin
            hi = lo - 1;
         end
         range_lo[k] = lo;
         range_hi[k] = hi;
         write_csr(CSR_RANGE_0 + CSR_INDEX_W'(k), {WATT_W'(hi), WATT_W'(lo)});
      end
      write_csr(CSR_RANGES_IN_USE,
                ($urandom_range(4) == 0) ? $urandom_range(7) : $urandom_range(4, 1));
   endtask

   // Mostly dwells on a configured range for a few samples, so that segments form,
   // with some samples anywhere on the scale and some raw noise.
   task automatic run_random(int count);
      int  watts_goal;
      int  dwell;
      int  pick;
      int  k;
      bit  noise;
      logic [SAMPLE_W-1:0] p;
      watts_goal = 0;
      dwell = 0;
      noise = 0;
      for (int i = 0; i < count; i++) begin
         if (i % 20 == 0) begin
            if ($urandom_range(3) == 0) begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end else begin
               send_idle_pct = phase_idle_pct;
               rsp_stall_pct = phase_stall_pct;
            end
         end
         if (dwell == 0) begin
            dwell = $urandom_range(5, 1);
            pick = $urandom_range(99);
            noise = (pick >= 90);
            k = $urandom_range(RANGE_REGS - 1);
            if (pick < 75 && range_lo[k] <= range_hi[k])
               watts_goal = $urandom_range(range_hi[k], range_lo[k]);
            else
               watts_goal = $urandom_range(int'(WATT_MAX));
         end
         dwell--;
         p = noise ? SAMPLE_W'($urandom()) : sample_for_watts(watts_goal);
         send_sample(p, $urandom_range(99) < 6);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      segments = new();
      phase_idle_pct = 9;
      phase_stall_pct = 72;
      send_idle_pct = 9;
      rsp_stall_pct = 72;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: one range of exactly zero watts, period of one.
      send_sample(20'd0, 1'b0);
      send_sample(20'd7, 1'b0);
      send_sample(20'd8, 1'b0);
      send_sample(20'hFFFFF, 1'b0);
      send_sample(20'd3, 1'b1);
      settle();

      // Overlapping ranges 0 and 1, an inverted range 2, range 3 at the top of the scale.
      write_csr(CSR_RANGE_0, {16'd200, 16'd100});
      write_csr(CSR_RANGE_0 + 3'd1, {16'd300, 16'd150});
      write_csr(CSR_RANGE_0 + 3'd2, {16'd400, 16'd500});
      write_csr(CSR_RANGE_3, {WATT_MAX, 16'd65000});
      write_csr(CSR_RANGES_IN_USE, 32'd4);
      write_csr(CSR_SAMPLE_PERIOD, {16'hA5A5, 16'd3});
      write_csr(CSR_UNMAPPED_LO, $urandom());
      write_csr(CSR_UNMAPPED_HI, $urandom());
      range_lo = '{100, 150, 500, 65000};
      range_hi = '{200, 300, 400, int'(WATT_MAX)};
      send_sample(20'hFFFFF, 1'b0);
      send_sample(20'd1048552, 1'b0);
      send_sample(20'd1039991, 1'b0);
      send_sample(20'd1592, 1'b0);
      send_sample(20'd3207, 1'b0);
      send_sample(20'd3208, 1'b0);
      send_sample(20'd2400, 1'b0);
      send_sample(20'd1591, 1'b0);
      send_sample(20'd7200, 1'b0);
      send_sample(20'd0, 1'b1);
      send_sample(20'd4000, 1'b0);
      send_sample(20'd4000, 1'b1);
      send_sample(20'd2400, 1'b0);
      send_sample(20'd4000, 1'b1);
      settle();

      // No range in use: nothing can be recognized.
      write_csr(CSR_RANGES_IN_USE, 32'd0);
      send_sample(20'd2400, 1'b0);
      send_sample(20'd2400, 1'b1);
      settle();

      // Count above the number of ranges, and time that stands still.
      write_csr(CSR_RANGES_IN_USE, 32'd7);
      write_csr(CSR_SAMPLE_PERIOD, 32'd0);
      send_sample(20'hFFFFF, 1'b0);
      send_sample(20'd2400, 1'b0);
      send_sample(20'd2400, 1'b1);
      settle();

      program_ranges();
      write_csr(CSR_SAMPLE_PERIOD, 32'd1);
      run_random(150);
      settle();

      phase_idle_pct = 72;
      phase_stall_pct = 9;
      program_ranges();
      write_csr(CSR_SAMPLE_PERIOD, 32'(WATT_MAX));
      run_random(150);
      settle();

      phase_idle_pct = 0;
      phase_stall_pct = 0;
      program_ranges();
      write_csr(CSR_SAMPLE_PERIOD, $urandom_range(65535));
      run_random(30);
      // The sender keeps offering transfers while the receiver holds off.
      hold_requests++;
      run_random(120);
      settle();

      if (segments.failures == 0)
         $display("power_state_segmenter test passed");
      else
         $display("power_state_segmenter test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/psseg_pkg.sv
rtl/psseg_front.sv
rtl/psseg_queue.sv
rtl/psseg_back.sv
rtl/power_state_segmenter.sv
tb/sv/psseg_tb_pkg.sv
tb/sv/tb_top.sv
